@@ design/planar_arm_forward_kinematics_defines.svh @@
// Assertion macros for the planar arm forward kinematics block.
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_DEFINES_SVH
`ifndef SYNTHESIS
`define PAFK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PAFK_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PAFK_ASSERT(label, clk, rst_n, prop, msg)
`define PAFK_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ design/pafk_pkg.sv @@
// Shared types, constants and the arctangent table for the arm kinematics block.
package pafk_pkg;
  localparam int CordicStages = 16;
  localparam int NumStages = (CordicStages > 24) ? 24 : CordicStages;
  localparam int PipeDepth = NumStages + 6;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam logic [1:0] RegLinkLength = 2'd0;
  localparam logic [1:0] RegBodyHeight = 2'd1;

  typedef logic signed [33:0] q30_t;
  typedef logic signed [33:0] zang_t;

  function automatic zang_t atan_turn(input int i);
    zang_t t;
    unique case (i)
      0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10679838;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;     16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;      19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;       22: t = 34'sd163;       23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage

@@ design/pafk_cordic.sv @@
// Pipelined CORDIC rotator producing cosine and sine of a binary angle in Q30.
module pafk_cordic (
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] angle,
  output pafk_pkg::q30_t cos_out,
  output pafk_pkg::q30_t sin_out
);
  localparam int N = pafk_pkg::NumStages;

  pafk_pkg::q30_t x_r [N+1];
  pafk_pkg::q30_t y_r [N+1];
  pafk_pkg::zang_t z_r [N+1];
  logic flip_r [N+1];

  logic signed [16:0] red;
  logic flip0;

  // Reduce the angle to [-90, 90) degrees; a half turn removed flips the result.
  always_comb begin
    flip0 = 1'b0;
    if (angle >= 16'd16384 && angle < 16'd49152) begin
      red = $signed({1'b0, angle}) - 17'sd32768;
      flip0 = 1'b1;
    end else if (angle >= 16'd49152) begin
      // Read as a 17-bit signed value this is the angle minus a full turn.
      red = $signed({1'b1, angle});
    end else begin
      red = $signed({1'b0, angle});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= pafk_pkg::GainQ30;
      y_r[0] <= '0;
      z_r[0] <= {red[16], red, 16'd0};
      flip_r[0] <= flip0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - pafk_pkg::atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + pafk_pkg::atan_turn(i);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  assign cos_out = flip_r[N] ? -x_r[N] : x_r[N];
  assign sin_out = flip_r[N] ? -y_r[N] : y_r[N];
endmodule

@@ design/planar_arm_forward_kinematics.sv @@
// Top level of the planar three-link arm forward kinematics pipeline.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | base_x, base_y, joint1..3_angle
//  out_    | output    | out_valid/out_stall| tip_x, tip_y, heading
//  cfg_    | input     | APB write/read     | link_length, body_height
//
// One beat is accepted every cycle unless in_stall is high; it passes through
// the angle sums, the CORDIC stage chain, the term sums, the length multiply
// and the final add with saturation. A stall on the output freezes the whole
// pipeline; the input stall is asserted only while the output is stalled with
// a full output stage. Reset clears valid bits and restores cfg registers.
`include "planar_arm_forward_kinematics_defines.svh"
module planar_arm_forward_kinematics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] in_base_x,
  input  logic signed [23:0] in_base_y,
  input  logic [15:0] in_joint1_angle,
  input  logic [15:0] in_joint2_angle,
  input  logic [15:0] in_joint3_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [23:0] out_tip_x,
  output logic signed [23:0] out_tip_y,
  output logic signed [15:0] out_heading,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int N = pafk_pkg::NumStages;
  localparam int D = pafk_pkg::PipeDepth;

  logic [9:0] link_length_r, body_height_r;
  logic [1:0] reg_idx;
  assign reg_idx = cfg_paddr[2] ? pafk_pkg::RegBodyHeight : pafk_pkg::RegLinkLength;
  assign cfg_pready = 1'b1;

  // Configuration registers; only two exist, so the address needs one bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_length_r <= 10'd50;
      body_height_r <= 10'd40;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      unique case (reg_idx)
        pafk_pkg::RegLinkLength: link_length_r <= cfg_pwdata[9:0];
        pafk_pkg::RegBodyHeight: body_height_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end
  // A write beyond the two registers lands on nothing.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == 3'd0) cfg_prdata = {22'd0, link_length_r};
    else if (cfg_paddr == 3'd4) cfg_prdata = {22'd0, body_height_r};
  end

  // The whole pipeline advances together unless the output holds a result
  // that is stalled.
  logic adv;
  logic [D-1:0] vld_r;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[D-2:0], in_valid};
  end
  assign out_valid = vld_r[D-1];

  // Stage A: joint angle sums.
  logic [15:0] a1_r, a2_r, a3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= in_joint1_angle;
      a2_r <= in_joint1_angle + in_joint2_angle;
      a3_r <= in_joint1_angle + in_joint2_angle + in_joint3_angle;
    end
  end

  pafk_pkg::q30_t c1, s1, c2, s2, c3, s3;
  pafk_cordic u_rot1 (.clk, .adv, .angle(a1_r), .cos_out(c1), .sin_out(s1));
  pafk_cordic u_rot2 (.clk, .adv, .angle(a2_r), .cos_out(c2), .sin_out(s2));
  pafk_cordic u_rot3 (.clk, .adv, .angle(a3_r), .cos_out(c3), .sin_out(s3));

  // Base position and heading ride in a delay line beside the rotators. The
  // base is tapped one entry early for the add stage, the heading at the end
  // for the output stage.
  localparam int LagS = N + 5;
  logic signed [23:0] bx_d [LagS], by_d [LagS];
  logic [15:0] hd_d [LagS];
  always_ff @(posedge clk) begin
    if (adv) begin
      bx_d[0] <= in_base_x;
      by_d[0] <= in_base_y;
      hd_d[0] <= in_joint1_angle + in_joint2_angle + in_joint3_angle + 16'd16384;
      for (int k = 1; k < LagS; k++) begin
        bx_d[k] <= bx_d[k-1];
        by_d[k] <= by_d[k-1];
        hd_d[k] <= hd_d[k-1];
      end
    end
  end

  // Stage B: sum of the three unit vectors in Q30.
  logic signed [35:0] sx_r, sy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= -(36'(s1) + 36'(s2) + 36'(s3));
      sy_r <= 36'(c1) + 36'(c2) + 36'(c3);
    end
  end

  // Stage C: scale by link length.
  logic signed [47:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= 48'(sx_r) * $signed({38'd0, link_length_r});
      py_r <= 48'(sy_r) * $signed({38'd0, link_length_r});
    end
  end

  // Stage D: round to 8 fraction bits, add base and body height.
  logic signed [26:0] tx_r, ty_r;
  logic signed [47:0] rx, ry;
  assign rx = (px_r + 48'sd2097152) >>> 22;
  assign ry = (py_r + 48'sd2097152) >>> 22;
  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r <= 27'(bx_d[LagS-2]) + rx[26:0];
      ty_r <= 27'(by_d[LagS-2]) + $signed({9'd0, body_height_r, 8'd0}) + ry[26:0];
    end
  end

  // Stage E: saturation and heading.
  logic [15:0] hd_r;
  logic signed [23:0] ox_r, oy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= (tx_r > 27'sd8388607) ? 24'sd8388607 :
              (tx_r < -27'sd8388608) ? -24'sd8388608 : tx_r[23:0];
      oy_r <= (ty_r > 27'sd8388607) ? 24'sd8388607 :
              (ty_r < -27'sd8388608) ? -24'sd8388608 : ty_r[23:0];
      hd_r <= (link_length_r == 10'd0) ? 16'd0 : hd_d[LagS-1];
    end
  end
  assign out_tip_x = ox_r;
  assign out_tip_y = oy_r;
  assign out_heading = $signed(hd_r);

  `PAFK_ASSERT(a_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped under stall")
  `PAFK_ASSERT(a_stall, clk, rst_n, in_stall == (out_valid && out_stall), "input stall mismatch")
  `PAFK_ASSERT_RST(a_rst, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule
